>>> sv/tcsa_pkg.sv
// Shared types, widths and helper functions for the three-channel sample averager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tcsa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 8;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int LANES       = 3;
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);
    localparam logic [STEP_BITS-1:0]  STEP_LAST   = STEP_BITS'(SUM_BITS - 1);

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_ACQUIRE  = 2'd1,
        PH_FINISHED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_PACK,
        DIV_OUT
    } t_div_state;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
    } t_in_item;

    typedef struct packed {
        logic                          done_res;
        logic signed [SAMPLE_BITS-1:0] avg_x;
        logic signed [SAMPLE_BITS-1:0] avg_y;
        logic signed [SAMPLE_BITS-1:0] avg_z;
    } t_out_item;

    // One queued job: the acquisition state left by one item.
    typedef struct packed {
        logic                       done;
        logic [COUNT_BITS-1:0]      count;
        logic signed [SUM_BITS-1:0] sum_x;
        logic signed [SUM_BITS-1:0] sum_y;
        logic signed [SUM_BITS-1:0] sum_z;
    } t_job;

    function automatic logic [SUM_BITS-1:0] magnitude(input logic signed [SUM_BITS-1:0] s);
        logic [SUM_BITS-1:0] u;
        u = SUM_BITS'(s);
        return s[SUM_BITS-1] ? (~u + SUM_BITS'(1)) : u;
    endfunction

    // Apply the sign to a quotient magnitude and clamp to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] signed_clamp(
        input logic                neg,
        input logic [SUM_BITS-1:0] q
    );
        logic [SUM_BITS-1:0]    pos_max;
        logic [SAMPLE_BITS-1:0] qs;
        pos_max = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
        qs      = q[SAMPLE_BITS-1:0];
        if (!neg) begin
            return (q > pos_max) ? SAMPLE_BITS'(pos_max) : qs;
        end
        if (q > pos_max + SUM_BITS'(1)) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        return ~qs + SAMPLE_BITS'(1);
    endfunction

endpackage

`default_nettype wire

>>> sv/three_channel_sample_averager.sv
// Three-channel sample averager, top level: front part, job queue and divider back part.
// Depends on tcsa_pkg, tcsa_front, tcsa_queue and tcsa_divider.
//
// Each input beat is either a start command or a frame of three signed samples.
// After a start the first frame is dropped and clears the sums; the frames that
// follow are summed per channel until sample_count frames are in, the frame after
// that ends the acquisition, and later frames are ignored. Every input beat gives
// exactly one output beat: the done flag and the three averages (sum divided by
// sample_count, truncated toward zero, clamped to the sample range; zero when the
// count is zero). The front part updates the acquisition state in the cycle a beat
// is taken and writes a job into a two-entry queue; input stall rises only while
// that queue is full. The back part divides all three channels together with a
// restoring divider, one quotient bit per cycle, and it finishes one item,
// including any output stall, before it takes the next; that divider sets the
// sustained rate. sample_count takes effect on the next beat and must be written
// only while the block is idle.
`default_nettype none

module three_channel_sample_averager (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tcsa_pkg::COUNT_BITS-1:0] i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire tcsa_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output tcsa_pkg::t_out_item                  o_out_item
);

    logic           in_accept;
    logic           q_full;
    logic           q_nonempty;
    logic           q_pop;
    tcsa_pkg::t_job front_job;
    tcsa_pkg::t_job head_job;

    // take a beat whenever the queue has room
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid & ~q_full;

    tcsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_item        (i_in_item),
        .o_job         (front_job)
    );

    tcsa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_accept),
        .i_job      (front_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_job      (head_job)
    );

    // hold each result beat in the divider's output register until taken
    tcsa_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_nonempty),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

>>> sv/tcsa_front.sv
// Front part: takes commands and frames, keeps the acquisition state, emits jobs.
// Depends on tcsa_pkg.
`default_nettype none

module tcsa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tcsa_pkg::COUNT_BITS-1:0] i_cfg_wr_data,
    input  wire logic                          i_accept,
    input  wire tcsa_pkg::t_in_item            i_item,
    output tcsa_pkg::t_job                     o_job
);

    tcsa_pkg::t_phase                       r_phase, n_phase;
    logic [tcsa_pkg::COUNT_BITS-1:0]        r_count;
    logic [tcsa_pkg::COUNT_BITS-1:0]        r_frames, n_frames;
    logic signed [tcsa_pkg::SUM_BITS-1:0]   r_sum_x, n_sum_x;
    logic signed [tcsa_pkg::SUM_BITS-1:0]   r_sum_y, n_sum_y;
    logic signed [tcsa_pkg::SUM_BITS-1:0]   r_sum_z, n_sum_z;

    always_comb begin
        n_phase  = r_phase;
        n_frames = r_frames;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_sum_z  = r_sum_z;
        if (i_item.kind) begin
            n_phase = tcsa_pkg::PH_START;
        end else begin
            case (r_phase)
                tcsa_pkg::PH_START: begin
                    // drop the first frame, clear the sums
                    n_frames = '0;
                    n_sum_x  = '0;
                    n_sum_y  = '0;
                    n_sum_z  = '0;
                    n_phase  = tcsa_pkg::PH_ACQUIRE;
                end
                tcsa_pkg::PH_ACQUIRE: begin
                    if (r_frames < r_count) begin
                        n_frames = r_frames + tcsa_pkg::COUNT_BITS'(1);
                        n_sum_x  = r_sum_x + tcsa_pkg::SUM_BITS'(i_item.sample_x);
                        n_sum_y  = r_sum_y + tcsa_pkg::SUM_BITS'(i_item.sample_y);
                        n_sum_z  = r_sum_z + tcsa_pkg::SUM_BITS'(i_item.sample_z);
                    end else begin
                        n_phase = tcsa_pkg::PH_FINISHED;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        o_job.done  = (n_phase == tcsa_pkg::PH_FINISHED);
        o_job.count = r_count;
        o_job.sum_x = n_sum_x;
        o_job.sum_y = n_sum_y;
        o_job.sum_z = n_sum_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tcsa_pkg::PH_FINISHED;
            r_count  <= tcsa_pkg::COUNT_RESET;
            r_frames <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_z  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_phase  <= n_phase;
                r_frames <= n_frames;
                r_sum_x  <= n_sum_x;
                r_sum_y  <= n_sum_y;
                r_sum_z  <= n_sum_z;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/tcsa_queue.sv
// Short job queue between the front and back parts.
// Depends on tcsa_pkg.
`default_nettype none

module tcsa_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tcsa_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_nonempty,
    output tcsa_pkg::t_job      o_job
);

    tcsa_pkg::t_job                 r_slot [tcsa_pkg::QUEUE_DEPTH];
    logic [tcsa_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [tcsa_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [tcsa_pkg::QUEUE_AW:0]    r_fill;

    assign o_full     = (r_fill == (tcsa_pkg::QUEUE_AW+1)'(tcsa_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_fill != '0);
    assign o_job      = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tcsa_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tcsa_pkg::QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (tcsa_pkg::QUEUE_AW+1)'(1);
                2'b01:   r_fill <= r_fill - (tcsa_pkg::QUEUE_AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/tcsa_divider.sv
// Back part: restoring divider, three lanes side by side, one quotient bit a cycle,
// then clamp and hold the result beat. Depends on tcsa_pkg.
`default_nettype none

module tcsa_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire tcsa_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output tcsa_pkg::t_out_item o_item
);

    tcsa_pkg::t_div_state               r_state, n_state;
    logic [tcsa_pkg::SUM_BITS-1:0]      r_mag [tcsa_pkg::LANES];
    logic [tcsa_pkg::SUM_BITS-1:0]      n_mag [tcsa_pkg::LANES];
    logic [tcsa_pkg::COUNT_BITS-1:0]    r_rem [tcsa_pkg::LANES];
    logic [tcsa_pkg::COUNT_BITS-1:0]    n_rem [tcsa_pkg::LANES];
    logic [tcsa_pkg::LANES-1:0]         r_neg, n_neg;
    logic [tcsa_pkg::COUNT_BITS-1:0]    r_count, n_count;
    logic                               r_done, n_done;
    logic [tcsa_pkg::STEP_BITS-1:0]     r_step, n_step;
    tcsa_pkg::t_out_item                r_out, n_out;
    logic [tcsa_pkg::COUNT_BITS:0]      trial [tcsa_pkg::LANES];
    logic [tcsa_pkg::SAMPLE_BITS-1:0]   avg [tcsa_pkg::LANES];

    assign o_valid = (r_state == tcsa_pkg::DIV_OUT);
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_count = r_count;
        n_done  = r_done;
        n_step  = r_step;
        n_out   = r_out;
        o_pop   = 1'b0;
        for (int l = 0; l < tcsa_pkg::LANES; l++) begin
            n_mag[l] = r_mag[l];
            n_rem[l] = r_rem[l];
            trial[l] = {r_rem[l], r_mag[l][tcsa_pkg::SUM_BITS-1]};
            avg[l]   = (r_count == '0) ? '0
                       : tcsa_pkg::signed_clamp(r_neg[l], r_mag[l]);
        end
        case (r_state)
            tcsa_pkg::DIV_IDLE: begin
                if (i_job_valid) begin
                    o_pop    = 1'b1;
                    n_count  = i_job.count;
                    n_done   = i_job.done;
                    n_step   = '0;
                    n_neg    = {i_job.sum_z[tcsa_pkg::SUM_BITS-1],
                                i_job.sum_y[tcsa_pkg::SUM_BITS-1],
                                i_job.sum_x[tcsa_pkg::SUM_BITS-1]};
                    n_mag[0] = tcsa_pkg::magnitude(i_job.sum_x);
                    n_mag[1] = tcsa_pkg::magnitude(i_job.sum_y);
                    n_mag[2] = tcsa_pkg::magnitude(i_job.sum_z);
                    for (int l = 0; l < tcsa_pkg::LANES; l++) begin
                        n_rem[l] = '0;
                    end
                    n_state  = tcsa_pkg::DIV_RUN;
                end
            end
            tcsa_pkg::DIV_RUN: begin
                // shift in the next dividend bit, subtract where it fits
                for (int l = 0; l < tcsa_pkg::LANES; l++) begin
                    if (trial[l] >= {1'b0, r_count}) begin
                        n_rem[l] = tcsa_pkg::COUNT_BITS'(trial[l] - {1'b0, r_count});
                        n_mag[l] = {r_mag[l][tcsa_pkg::SUM_BITS-2:0], 1'b1};
                    end else begin
                        n_rem[l] = trial[l][tcsa_pkg::COUNT_BITS-1:0];
                        n_mag[l] = {r_mag[l][tcsa_pkg::SUM_BITS-2:0], 1'b0};
                    end
                end
                n_step = r_step + tcsa_pkg::STEP_BITS'(1);
                if (r_step == tcsa_pkg::STEP_LAST) begin
                    n_state = tcsa_pkg::DIV_PACK;
                end
            end
            tcsa_pkg::DIV_PACK: begin
                n_out.done_res = r_done;
                n_out.avg_x    = avg[0];
                n_out.avg_y    = avg[1];
                n_out.avg_z    = avg[2];
                n_state        = tcsa_pkg::DIV_OUT;
            end
            tcsa_pkg::DIV_OUT: begin
                if (!i_stall) begin
                    n_state = tcsa_pkg::DIV_IDLE;
                end
            end
            default: begin
                n_state = tcsa_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_count <= n_count;
        r_done  <= n_done;
        r_step  <= n_step;
        r_out   <= n_out;
        for (int l = 0; l < tcsa_pkg::LANES; l++) begin
            r_mag[l] <= n_mag[l];
            r_rem[l] <= n_rem[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcsa_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
